// ===== src/cia_pkg.sv =====
package cia_pkg;

  localparam int WIDTH = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     func;
    logic signed [WIDTH-1:0] a;
    logic signed [WIDTH-1:0] b;
  } in_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] value;
    logic                    error;
  } out_t;

  // One item as it walks down the divider chain. Non-divide items carry
  // their finished result in res; divide items refine rem and dq per cell.
  typedef struct packed {
    logic             vld;
    op_t              func;
    logic             err;
    logic [WIDTH-1:0] res;
    logic             neg;
    logic [WIDTH-1:0] rem;
    logic [WIDTH-1:0] dq;
    logic [WIDTH-1:0] dvs;
  } tok_t;

endpackage

// ===== src/cia_cell.sv =====
module cia_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  cia_pkg::tok_t tok_in,
  output cia_pkg::tok_t tok_out
);
  import cia_pkg::*;

  tok_t               tok_r;
  tok_t               tok_nxt;
  logic [WIDTH:0]     shifted;
  logic [WIDTH:0]     trial;

  // One restoring division step: shift in the next dividend bit and try
  // to subtract the divisor magnitude.
  always_comb begin
    shifted = {tok_in.rem, tok_in.dq[WIDTH-1]};
    trial   = shifted - {1'b0, tok_in.dvs};
    tok_nxt = tok_in;
    if (!trial[WIDTH]) begin
      tok_nxt.rem = trial[WIDTH-1:0];
      tok_nxt.dq  = {tok_in.dq[WIDTH-2:0], 1'b1};
    end else begin
      tok_nxt.rem = shifted[WIDTH-1:0];
      tok_nxt.dq  = {tok_in.dq[WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== src/checked_integer_alu.sv =====
// Checked signed ALU: each item carries an operation (add, subtract,
// multiply, divide) and two signed WIDTH-bit operands, and yields one result
// item holding either the exact result or an error flag with a zero value.
// Overflow of add, subtract and multiply, a zero divisor, and the most
// negative value divided by minus one all raise the error flag. Division
// truncates toward zero. The block accepts one item every cycle unless a
// finished result waits, and each item passes in turn through the front
// stage, the chain of WIDTH divider cells, each producing one quotient bit,
// and the output register. Every item passes through the whole chain so that
// results leave in the order the items came in. The whole pipeline moves
// together: it advances whenever the output register is empty or its item is
// being taken, so in_ready falls only while a finished result waits.
module checked_integer_alu (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cia_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cia_pkg::out_t out_data
);
  import cia_pkg::*;

  logic adv;

  // Front stage: add and subtract with overflow, the divide error check, the
  // full product, and the operand magnitudes for the divider.
  logic                      fa_vld_r;
  op_t                       fa_func_r;
  logic                      fa_err_r;
  logic [WIDTH-1:0]          fa_res_r;
  logic signed [2*WIDTH-1:0] fa_prod_r;
  logic [WIDTH-1:0]          fa_amag_r;
  logic [WIDTH-1:0]          fa_bmag_r;
  logic                      fa_neg_r;

  logic [WIDTH:0]   sum;
  logic [WIDTH:0]   dif;
  logic [WIDTH-1:0] amag;
  logic [WIDTH-1:0] bmag;
  logic             derr;
  logic             aserr;
  logic [WIDTH-1:0] asres;

  tok_t chain [0:WIDTH];

  logic  out_valid_r;
  out_t  out_data_r;
  logic  mul_err;
  tok_t  last;
  logic [WIDTH-1:0] quo;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    sum   = {in_data.a[WIDTH-1], in_data.a} + {in_data.b[WIDTH-1], in_data.b};
    dif   = {in_data.a[WIDTH-1], in_data.a} - {in_data.b[WIDTH-1], in_data.b};
    amag  = in_data.a[WIDTH-1] ? (~in_data.a + 1'b1) : in_data.a;
    bmag  = in_data.b[WIDTH-1] ? (~in_data.b + 1'b1) : in_data.b;
    // Zero divisor, or the most negative value over minus one.
    derr  = (in_data.b == '0) ||
            ((in_data.a == {1'b1, {(WIDTH-1){1'b0}}}) && (in_data.b == '1));
    case (in_data.func)
      OP_ADD: begin
        aserr = sum[WIDTH] != sum[WIDTH-1];
        asres = sum[WIDTH-1:0];
      end
      OP_SUB: begin
        aserr = dif[WIDTH] != dif[WIDTH-1];
        asres = dif[WIDTH-1:0];
      end
      OP_DIV: begin
        aserr = derr;
        asres = '0;
      end
      default: begin
        aserr = 1'b0;
        asres = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_vld_r <= 1'b0;
    end else if (adv) begin
      fa_vld_r  <= in_valid;
      fa_func_r <= in_data.func;
      fa_err_r  <= aserr;
      fa_res_r  <= asres;
      fa_prod_r <= in_data.a * in_data.b;
      fa_amag_r <= amag;
      fa_bmag_r <= bmag;
      fa_neg_r  <= in_data.a[WIDTH-1] ^ in_data.b[WIDTH-1];
    end
  end

  // The product fits only when its upper half and the sign of the lower
  // half all agree.
  assign mul_err = fa_prod_r[2*WIDTH-1:WIDTH-1] != {(WIDTH+1){fa_prod_r[WIDTH-1]}};

  always_comb begin
    chain[0].vld  = fa_vld_r;
    chain[0].func = fa_func_r;
    chain[0].neg  = fa_neg_r;
    chain[0].rem  = '0;
    chain[0].dq   = fa_amag_r;
    chain[0].dvs  = fa_bmag_r;
    if (fa_func_r == OP_MUL) begin
      chain[0].err = mul_err;
      chain[0].res = mul_err ? '0 : fa_prod_r[WIDTH-1:0];
    end else begin
      chain[0].err = fa_err_r;
      chain[0].res = fa_err_r ? '0 : fa_res_r;
    end
  end

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    cia_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign last = chain[WIDTH];
  assign quo  = last.neg ? (~last.dq + 1'b1) : last.dq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r      <= last.vld;
      out_data_r.error <= last.err;
      if (last.err) begin
        out_data_r.value <= '0;
      end else if (last.func == OP_DIV) begin
        out_data_r.value <= quo;
      end else begin
        out_data_r.value <= last.res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.value == '0)
    else $error("error item with nonzero value");

  a_hold_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(chain[WIDTH]))
    else $error("divider chain moved while stalled");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(fa_vld_r) && $stable(fa_prod_r))
    else $error("front stage moved while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !fa_vld_r)
    else $error("pipeline not empty after reset");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// Testbench for checked_integer_alu. Items carrying an operation and two
// signed operands are sent through a valid/ready channel. For each accepted
// item the expected result is computed here with 64-bit arithmetic and queued.
// Each result taken from the output channel is compared with the oldest
// queued expectation. Both sides idle in random bursts, except near the end
// of the run. One phase stalls the receiver for a long stretch so that the
// pipeline fills up and back-pressures the input.
module testbench;
  import cia_pkg::*;

  localparam int LATENCY = WIDTH + 2;
  localparam logic signed [WIDTH-1:0] MAX_VAL = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic signed [WIDTH-1:0] MIN_VAL = {1'b1, {(WIDTH-1){1'b0}}};

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  out_t expected_results[$];
  int   failures;
  int   results_checked;
  int   error_results;
  // These flags steer the receiver and the sender. Random idling can be
  // switched off on either side, and a long receiver hold-off can be requested.
  bit   rx_idle_enable;
  bit   rx_hold_request;
  bit   tx_idle_enable;

  checked_integer_alu dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // This function computes the exact result in 64 bits. If that result does
  // not fit the signed WIDTH-bit range, it flags an error and returns 0.
  function automatic out_t alu_result(in_t item);
    longint x;
    longint y;
    longint exact;
    out_t r;
    x = longint'(item.a);
    y = longint'(item.b);
    r.error = 1'b0;
    exact = 0;
    case (item.func)
      OP_ADD: exact = x + y;
      OP_SUB: exact = x - y;
      OP_MUL: exact = x * y;
      default: begin
        // A zero divisor is an error. So is the most negative value divided
        // by minus one, because its quotient is out of range. The division
        // operator of SystemVerilog truncates toward zero.
        if (y == 0) r.error = 1'b1;
        else exact = x / y;
      end
    endcase
    if (exact > longint'(MAX_VAL) || exact < longint'(MIN_VAL)) r.error = 1'b1;
    r.value = r.error ? '0 : exact[WIDTH-1:0];
    return r;
  endfunction

  // This task sends one item and returns at the edge where it is accepted.
  // A random gap may come first, with valid low. Valid is raised and held
  // until in_ready is seen high at a rising edge, and it stays high after
  // that so that items can follow back to back.
  task automatic send_item(op_t op, logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
    in_t item;
    int gap;
    item.func = op;
    item.a = a;
    item.b = b;
    if (tx_idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(alu_result(item));
  endtask

  // This function returns a random operand. Three of eight choices are fully random.
  // The rest are chosen near zero, near the limits, or as small values, so
  // that overflow and sign cases show up often.
  function automatic logic [WIDTH-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return MAX_VAL - $urandom_range(0, 3);
      1: return MIN_VAL + $urandom_range(0, 3);
      2: return $urandom_range(0, 4) - 2;
      3: return $urandom_range(0, 131071) - 65536;
      4: return $urandom_range(0, 200000) - 100000;
      default: return $urandom;
    endcase
  endfunction

  // This task drops valid and waits until every expected result has been
  // checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    send_item(OP_ADD, MAX_VAL, 1);
    send_item(OP_ADD, MIN_VAL, -1);
    send_item(OP_ADD, MAX_VAL, MIN_VAL);
    send_item(OP_ADD, MAX_VAL, 0);
    send_item(OP_SUB, MIN_VAL, 1);
    send_item(OP_SUB, 0, MIN_VAL);
    send_item(OP_SUB, -1, MIN_VAL);
    send_item(OP_SUB, MAX_VAL, -1);
    send_item(OP_MUL, MIN_VAL, -1);
    send_item(OP_MUL, 65536, 32768);
    send_item(OP_MUL, -65536, 32768);
    send_item(OP_MUL, MAX_VAL, -1);
    send_item(OP_MUL, 46341, 46341);
    send_item(OP_MUL, 0, MIN_VAL);
    send_item(OP_DIV, 7, 0);
    send_item(OP_DIV, MIN_VAL, -1);
    send_item(OP_DIV, -7, 2);
    send_item(OP_DIV, 7, -2);
    send_item(OP_DIV, MIN_VAL, 1);
    send_item(OP_DIV, MAX_VAL, MIN_VAL);
    send_item(OP_DIV, MIN_VAL, MAX_VAL);
    send_item(OP_DIV, 0, -1);
    wait_drained();
  endtask

  task automatic test_random_ops(int count);
    repeat (count) send_item(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
  endtask

  // In this test the receiver holds off for a long stretch. The sender keeps
  // offering items during that time, so the pipeline fills and then stalls
  // the input.
  task automatic test_backpressure();
    rx_hold_request = 1'b1;
    test_random_ops(100);
    rx_hold_request = 1'b0;
    wait_drained();
  endtask

  // This process drives out_ready. It can hold off for a long stretch, or
  // idle in short random bursts, or stay ready all the time.
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (rx_hold_request) begin
        out_ready <= 1'b0;
        repeat (3 * LATENCY) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
      end else if (rx_idle_enable && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 24);
        out_ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // This process checks each result taken from the output channel.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding: value %0d error %0b",
               out_data.value, out_data.error);
        failures++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.error) error_results++;
        if (out_data.value !== want.value) begin
          $error("value mismatch: expected %0d, actual %0d", want.value, out_data.value);
          failures++;
        end
        if (out_data.error !== want.error) begin
          $error("error mismatch: expected %0b, actual %0b", want.error, out_data.error);
          failures++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    failures = 0;
    results_checked = 0;
    error_results = 0;
    rx_idle_enable = 1'b1;
    tx_idle_enable = 1'b1;
    rx_hold_request = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_random_ops(600);
    test_backpressure();
    // The last part of the run has no idling on either side.
    rx_idle_enable = 1'b0;
    tx_idle_enable = 1'b0;
    test_random_ops(630);
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      failures++;
    end

    $display("Checked %0d results, %0d of them flagged as errors.",
             results_checked, error_results);
    $display("The run covered all four operations, overflow limits and stalls on both sides.");
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
